// ===== rtl/fixed_point_matrix_stack_core_assert.svh =====
// Assertion macros for the matrix stack core.
`ifndef FIXED_POINT_MATRIX_STACK_CORE_ASSERT_SVH
`define FIXED_POINT_MATRIX_STACK_CORE_ASSERT_SVH
// assert that a implies b on the next clock
`define FPMS_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
// assert that a implies b in the same clock
`define FPMS_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`endif

// ===== rtl/fpms_pkg.sv =====
// Package: constants, opcodes and types of the matrix stack core.
`default_nettype none
package fpms_pkg;
   localparam int STACK_DEPTH_DEF   = 32;
   localparam int FRACTION_BITS_DEF = 14;
   localparam int ELEMS             = 12;

   typedef enum logic [3:0] {
      FN_PUSH   = 4'd0,
      FN_PUSHID = 4'd1,
      FN_POP    = 4'd2,
      FN_ROTX   = 4'd3,
      FN_ROTY   = 4'd4,
      FN_ROTZ   = 4'd5,
      FN_TREL   = 4'd6,
      FN_TABS   = 4'd7,
      FN_TSET   = 4'd8,
      FN_READ   = 4'd9
   } func_type;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic [3:0] IDX_RESET = 4'd12;

   localparam logic [1:0] CSR_OX = 2'd0;
   localparam logic [1:0] CSR_OY = 2'd1;
   localparam logic [1:0] CSR_OZ = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CALC,
      S_WRITE,
      S_CLEAR,
      S_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/fpms_store.sv =====
// Matrix store: one synchronous memory with a registered read port.
`default_nettype none
module fpms_store #(
   parameter int ADDR_W = 9,
   parameter int DEPTH  = 384
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [31:0]       wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [31:0]       rdata
);
   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/fixed_point_matrix_stack_core.sv =====
// Top level of the fixed-point 3x4 transform matrix stack.
`default_nettype none
// Keeps a stack of 3x4 fixed-point matrices in one single-port-write,
// one-read memory. After reset a clearing pass zeroes the store; no word is
// accepted meanwhile. Each operation then walks the twelve elements of the
// top entry one address a cycle: load, compute one element a cycle, write
// back and post the result. No new word is taken until the result of the
// last one is posted, as the single memory port and the element-serial
// datapath serve one word at a time; a result held off by the receiver
// holds off the next word as well. Rotations use FRACTION_BITS fraction
// bits, sums wrap at 32 bits. One result word per request word.
module fixed_point_matrix_stack_core #(
   parameter int STACK_DEPTH   = fpms_pkg::STACK_DEPTH_DEF,
   parameter int FRACTION_BITS = fpms_pkg::FRACTION_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // func[3:0], sine[19:4], cosine[35:20], dx[67:36], dy[99:68], dz[131:100],
   // element_index[135:132]
   input  wire logic [135:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0], level[6:2], element_value[38:7], zero fill [39]
   output logic      [39:0]  rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);
   localparam int WORDS  = STACK_DEPTH * fpms_pkg::ELEMS;
   localparam int ADDR_W = $clog2(WORDS);
   localparam int LVL_W  = $clog2(STACK_DEPTH);

   fpms_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [3:0]  elem_ff, elem_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic [31:0] m_ff [12];
   logic [31:0] ox_ff, oy_ff, oz_ff;
   logic [135:0] cmd_ff;
   logic [1:0]  st_ff, st_in;
   logic [31:0] val_ff, val_in;
   logic        rv_ff, rv_in;

   logic              we;
   logic [ADDR_W-1:0] waddr, raddr, base;
   logic [31:0]       wdata, rdata;

   fpms_store #(.ADDR_W(ADDR_W), .DEPTH(WORDS)) u_store (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   logic [3:0]  fn, idx;
   logic signed [31:0] sn, cs;
   logic [31:0] dx, dy, dz;
   logic zero_ang, full;
   assign fn  = cmd_ff[3:0];
   assign sn  = {{16{cmd_ff[19]}}, cmd_ff[19:4]};
   assign cs  = {{16{cmd_ff[35]}}, cmd_ff[35:20]};
   assign dx  = cmd_ff[67:36];
   assign dy  = cmd_ff[99:68];
   assign dz  = cmd_ff[131:100];
   assign idx = cmd_ff[135:132];
   assign zero_ang = (sn == 32'sd0) && (cs == (32'sd1 <<< FRACTION_BITS));
   assign full = ({1'b0, lvl_ff} + 1'b1) >= (LVL_W+1)'(STACK_DEPTH);
   assign base = ADDR_W'(lvl_ff * fpms_pkg::ELEMS);

   // compute one element at a time in S_CALC: elem_ff selects the target
   logic [1:0] row, col;
   logic [31:0] a, b, c, mul1, mul2, mul3, nv;
   logic [63:0] p1;
   logic [31:0] unit;
   assign unit = 32'd1 << FRACTION_BITS;
   assign row = elem_ff[3:2];
   assign col = elem_ff[1:0];

   always_comb begin
      logic [31:0] ca, cb, sg, tx, ty, tz;
      logic [1:0] ia, ib;
      ia = 2'd1; ib = 2'd2; sg = sn;
      case (fn)
         fpms_pkg::FN_ROTY: begin ia = 2'd0; ib = 2'd2; sg = 32'd0 - sn; end
         fpms_pkg::FN_ROTZ: begin ia = 2'd0; ib = 2'd1; end
         default: ;
      endcase
      ca = m_ff[{row, ia}];
      cb = m_ff[{row, ib}];
      tx = dx; ty = dy; tz = dz;
      if (fn == fpms_pkg::FN_TABS) begin
         tx = dx - ox_ff; ty = dy - oy_ff; tz = dz - oz_ff;
      end
      mul1 = m_ff[{row, 2'd0}] * tx;
      mul2 = m_ff[{row, 2'd1}] * ty;
      mul3 = m_ff[{row, 2'd2}] * tz;
      a = 32'd0; b = 32'd0; c = 32'd0; p1 = 64'd0;
      nv = m_ff[elem_ff];
      case (fn)
         fpms_pkg::FN_ROTX, fpms_pkg::FN_ROTY, fpms_pkg::FN_ROTZ: begin
            if (!zero_ang) begin
               if (col == ia) begin
                  a = ca * cs; b = cb * sg; c = a + b;
               end else begin
                  a = cb * cs; b = ca * sg; c = a - b;
               end
               if (col == ia || col == ib) begin
                  p1 = {{32{c[31]}}, c} >> FRACTION_BITS;
                  nv = p1[31:0];
               end
            end
         end
         fpms_pkg::FN_TREL: if (col == 2'd3) nv = m_ff[elem_ff] + mul1 + mul2 + mul3;
         fpms_pkg::FN_TABS: if (col == 2'd3) nv = mul1 + mul2 + mul3;
         fpms_pkg::FN_TSET: begin
            if (col == 2'd3) begin
               case (row)
                  2'd0: nv = dx << FRACTION_BITS;
                  2'd1: nv = dy << FRACTION_BITS;
                  default: nv = dz << FRACTION_BITS;
               endcase
            end
         end
         fpms_pkg::FN_PUSHID: nv = (row == col) ? unit : 32'd0;
         default: ;
      endcase
   end

   logic [31:0] nv_ff [12];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpms_pkg::S_CLEAR:
            if (cnt_ff == ADDR_W'(WORDS-1)) state_in = fpms_pkg::S_IDLE;
         fpms_pkg::S_IDLE:
            if (req_tvalid && (!rv_ff || rsp_tready)) state_in = fpms_pkg::S_READ;
         fpms_pkg::S_READ:  if (elem_ff == 4'd12) state_in = fpms_pkg::S_CALC;
         fpms_pkg::S_CALC:  if (elem_ff == 4'd11) state_in = fpms_pkg::S_WRITE;
         fpms_pkg::S_WRITE: if (elem_ff == 4'd11) state_in = fpms_pkg::S_OUT;
         fpms_pkg::S_OUT:   if (!rv_ff || rsp_tready) state_in = fpms_pkg::S_IDLE;
         default: state_in = fpms_pkg::S_CLEAR;
      endcase
   end

   // outputs and datapath control
   logic wr_en, push_ok;
   assign push_ok = (fn == fpms_pkg::FN_PUSH || fn == fpms_pkg::FN_PUSHID) && !full;
   always_comb begin
      cnt_in = cnt_ff; elem_in = elem_ff; lvl_in = lvl_ff;
      st_in = st_ff; val_in = val_ff; rv_in = rv_ff;
      we = 1'b0; waddr = cnt_ff; wdata = 32'd0; raddr = base;
      req_tready = 1'b0;
      wr_en = !(fn == fpms_pkg::FN_POP || fn == fpms_pkg::FN_READ || fn > 4'd9)
              && !((fn == fpms_pkg::FN_PUSH || fn == fpms_pkg::FN_PUSHID) && full);
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (state_ff)
         fpms_pkg::S_CLEAR: begin
            we = 1'b1; cnt_in = cnt_ff + 1'b1;
         end
         fpms_pkg::S_IDLE: begin
            req_tready = !rv_ff || rsp_tready;
            elem_in = 4'd0;
         end
         fpms_pkg::S_READ: begin
            raddr = base + ADDR_W'(elem_ff);
            elem_in = (elem_ff == 4'd12) ? 4'd0 : elem_ff + 1'b1;
         end
         fpms_pkg::S_CALC: elem_in = (elem_ff == 4'd11) ? 4'd0 : elem_ff + 1'b1;
         fpms_pkg::S_WRITE: begin
            we = wr_en;
            waddr = base + ADDR_W'(push_ok ? 4'd12 : 4'd0) + ADDR_W'(elem_ff);
            wdata = nv_ff[elem_ff];
            elem_in = (elem_ff == 4'd11) ? 4'd0 : elem_ff + 1'b1;
         end
         fpms_pkg::S_OUT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1; st_in = fpms_pkg::ST_DONE; val_in = 32'd0;
               case (fn)
                  fpms_pkg::FN_PUSH, fpms_pkg::FN_PUSHID:
                     if (full) st_in = fpms_pkg::ST_FULL;
                     else lvl_in = lvl_ff + 1'b1;
                  fpms_pkg::FN_POP:
                     if (lvl_ff == '0) st_in = fpms_pkg::ST_EMPTY;
                     else lvl_in = lvl_ff - 1'b1;
                  fpms_pkg::FN_READ:
                     if (idx < 4'd12) val_in = m_ff[idx];
                     else if (idx == fpms_pkg::IDX_RESET) lvl_in = '0;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fpms_pkg::S_CLEAR;
         cnt_ff <= '0; elem_ff <= '0; lvl_ff <= '0; rv_ff <= 1'b0;
         ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in; elem_ff <= elem_in; lvl_ff <= lvl_in; rv_ff <= rv_in;
         if (csr_we) begin
            case (csr_index)
               fpms_pkg::CSR_OX: ox_ff <= csr_wdata;
               fpms_pkg::CSR_OY: oy_ff <= csr_wdata;
               fpms_pkg::CSR_OZ: oz_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in; val_ff <= val_in;
      if (state_ff == fpms_pkg::S_IDLE && req_tready && req_tvalid) cmd_ff <= req_tdata;
      // read data lands in the cycle after its address
      if (state_ff == fpms_pkg::S_READ && elem_ff != 4'd0) m_ff[elem_ff - 1'b1] <= rdata;
      if (state_ff == fpms_pkg::S_CALC) nv_ff[elem_ff] <= nv;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {1'b0, val_ff, 5'(lvl_ff), st_ff};
endmodule
`default_nettype wire

// ===== rtl/fpms_checker.sv =====
// Port checker for the matrix stack core, bound to the top level.
`default_nettype none
`include "fixed_point_matrix_stack_core_assert.svh"
module fpms_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [39:0]  rsp_tdata
);
   `FPMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `FPMS_ASSERT_NOW(a_status_code, clock, reset, rsp_tvalid, rsp_tdata[1:0] <= fpms_pkg::ST_EMPTY)
   `FPMS_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `FPMS_ASSERT_NOW(a_zero_value, clock, reset, rsp_tvalid && rsp_tdata[1:0] != fpms_pkg::ST_DONE, rsp_tdata[38:7] == 32'd0)
endmodule

bind fixed_point_matrix_stack_core fpms_checker u_fpms_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

// ===== bench/matrix_stack_checker.sv =====
`timescale 1ns / 1ps
// Checker for the matrix stack core: predicts each result word and compares.
module matrix_stack_checker #(
   parameter int STACK_DEPTH   = fpms_pkg::STACK_DEPTH_DEF,
   parameter int FRACTION_BITS = fpms_pkg::FRACTION_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [135:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [39:0]  rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata,
   output int                fail_count,
   output int                pending_count,
   output int                result_count
);
   typedef struct packed {
      logic [31:0] value;
      logic [4:0]  level;
      logic [1:0]  status;
   } result_type;

   logic [31:0] stack_mem [STACK_DEPTH*fpms_pkg::ELEMS];
   int unsigned top_level;
   logic [31:0] origin [3];
   result_type  expected_q [$];

   function automatic logic [31:0] shift_fraction(logic [31:0] v);
      return $unsigned($signed(v) >>> FRACTION_BITS);
   endfunction

   task automatic rotate_pair(int ca, int cb, logic [31:0] c, logic [31:0] s);
      int base;
      logic [31:0] a, b;
      base = top_level * fpms_pkg::ELEMS;
      for (int r = 0; r < 3; r++) begin
         a = stack_mem[base + r*4 + ca];
         b = stack_mem[base + r*4 + cb];
         stack_mem[base + r*4 + ca] = shift_fraction(a*c + b*s);
         stack_mem[base + r*4 + cb] = shift_fraction(b*c - a*s);
      end
   endtask

   task automatic move_origin(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit add);
      int base;
      logic [31:0] sum;
      base = top_level * fpms_pkg::ELEMS;
      for (int r = 0; r < 3; r++) begin
         sum = stack_mem[base+r*4]*x + stack_mem[base+r*4+1]*y + stack_mem[base+r*4+2]*z;
         stack_mem[base+r*4+3] = add ? stack_mem[base+r*4+3] + sum : sum;
      end
   endtask

   task automatic apply_word(logic [135:0] w);
      logic [3:0]  fn, idx;
      logic [31:0] s, c, dx, dy, dz, unit;
      int base;
      result_type res;
      bit still;
      fn = w[3:0];
      s = {{16{w[19]}}, w[19:4]};
      c = {{16{w[35]}}, w[35:20]};
      dx = w[67:36]; dy = w[99:68]; dz = w[131:100];
      idx = w[135:132];
      unit = 32'd1 << FRACTION_BITS;
      still = (s == 0) && (c == unit);
      res = '0;
      base = top_level * fpms_pkg::ELEMS;
      case (fn)
         fpms_pkg::FN_PUSH, fpms_pkg::FN_PUSHID: begin
            if (top_level + 1 >= STACK_DEPTH) res.status = fpms_pkg::ST_FULL;
            else begin
               for (int i = 0; i < fpms_pkg::ELEMS; i++)
                  stack_mem[base+fpms_pkg::ELEMS+i] = (fn == fpms_pkg::FN_PUSH) ?
                     stack_mem[base+i] : ((i == 0 || i == 5 || i == 10) ? unit : '0);
               top_level++;
            end
         end
         fpms_pkg::FN_POP:
            if (top_level == 0) res.status = fpms_pkg::ST_EMPTY; else top_level--;
         fpms_pkg::FN_ROTX: if (!still) rotate_pair(1, 2, c, s);
         fpms_pkg::FN_ROTY: if (!still) rotate_pair(0, 2, c, -s);
         fpms_pkg::FN_ROTZ: if (!still) rotate_pair(0, 1, c, s);
         fpms_pkg::FN_TREL: move_origin(dx, dy, dz, 1'b1);
         fpms_pkg::FN_TABS:
            move_origin(dx - origin[0], dy - origin[1], dz - origin[2], 1'b0);
         fpms_pkg::FN_TSET: begin
            stack_mem[base+3]  = dx << FRACTION_BITS;
            stack_mem[base+7]  = dy << FRACTION_BITS;
            stack_mem[base+11] = dz << FRACTION_BITS;
         end
         fpms_pkg::FN_READ: begin
            if (idx < fpms_pkg::ELEMS) res.value = stack_mem[base+idx];
            else if (idx == fpms_pkg::IDX_RESET) top_level = 0;
         end
         default: ;
      endcase
      res.level = top_level[4:0];
      expected_q.push_back(res);
   endtask

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         for (int i = 0; i < STACK_DEPTH*fpms_pkg::ELEMS; i++) stack_mem[i] = '0;
         top_level = 0;
         origin = '{default: '0};
         expected_q.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (csr_we && csr_index <= fpms_pkg::CSR_OZ) origin[csr_index] = csr_wdata;
         if (req_tvalid && req_tready) apply_word(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[38:0];
            result_count <= result_count + 1;
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result word %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got !== want || rsp_tdata[39] !== 1'b0) begin
                  if (fail_count < 10)
                     $display("mismatch: status %0d/%0d level %0d/%0d value %h/%h (exp/got)",
                        want.status, got.status, want.level, got.level,
                        want.value, got.value);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the matrix stack core.
module testbench;
   localparam int STACK_DEPTH = fpms_pkg::STACK_DEPTH_DEF;
   localparam int IDLE_LIMIT  = 5000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [135:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic csr_we = 0;
   logic [1:0] csr_index = fpms_pkg::CSR_OX;
   logic [31:0] csr_wdata = '0;
   int fail_count, pending_count, result_count;
   bit calm = 0;
   bit hold_start = 0;
   bit hold_rsp = 0;
   int sent = 0;
   int rot_count = 0, trans_count = 0, stack_count = 0;

   always #10 clock = ~clock;

   fixed_point_matrix_stack_core dut (.*);

   matrix_stack_checker checker_i (.*);

   // receiver: random stall bursts, a long hold-off on request
   always @(posedge clock) begin
      int gap;
      if (reset) rsp_tready <= 0;
      else if (hold_rsp) rsp_tready <= 0;
      else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 0;
         gap = $urandom_range(1, 15);
         repeat (gap - 1) @(posedge clock);
      end else rsp_tready <= 1;
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      int quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [15:0] rand_trig();
      case ($urandom_range(0, 4))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'd0;
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function automatic logic [31:0] rand_val();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 64) - 32;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(logic [3:0] fn, logic [15:0] s, logic [15:0] c,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [3:0] idx);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         gap = $urandom_range(1, 15);
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {idx, z, y, x, c, s, fn};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      sent++;
      if (fn >= fpms_pkg::FN_ROTX && fn <= fpms_pkg::FN_ROTZ) rot_count++;
      else if (fn >= fpms_pkg::FN_TREL && fn <= fpms_pkg::FN_TSET) trans_count++;
      else stack_count++;
   endtask

   task automatic send_random();
      logic [3:0] fn;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) fn = fpms_pkg::FN_PUSH;
      else if (pick < 18) fn = fpms_pkg::FN_PUSHID;
      else if (pick < 28) fn = fpms_pkg::FN_POP;
      else if (pick < 52) fn = 4'(fpms_pkg::FN_ROTX + $urandom_range(0, 2));
      else if (pick < 70) fn = 4'(fpms_pkg::FN_TREL + $urandom_range(0, 2));
      else if (pick < 96) fn = fpms_pkg::FN_READ;
      else fn = 4'($urandom_range(10, 15));
      send_word(fn, (pick % 7 == 0) ? 16'd0 : rand_trig(),
                (pick % 7 == 0) ? 16'd16384 : rand_trig(),
                rand_val(), rand_val(), rand_val(),
                (fn == fpms_pkg::FN_READ && $urandom_range(0, 9) == 0) ?
                   4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11)));
   endtask

   task automatic drain();
      int spin;
      spin = 0;
      req_tvalid <= 0;
      while (pending_count != 0 && spin < 20000) begin
         @(posedge clock);
         spin++;
      end
      repeat (80) @(posedge clock);
   endtask

   // the caller drops csr_we after its last write
   task automatic write_origin(logic [1:0] idx, logic [31:0] v);
      csr_index <= idx;
      csr_wdata <= v;
      csr_we <= 1;
      @(posedge clock);
   endtask

   initial begin
      int spin;
      repeat (10) @(posedge clock);
      reset <= 0;
      write_origin(fpms_pkg::CSR_OX, 32'h7fff_ffff);
      write_origin(fpms_pkg::CSR_OY, 32'h8000_0000);
      write_origin(fpms_pkg::CSR_OZ, 32'd5);
      csr_we <= 0;

      // directed: empty pop, identity, every rotation, translations, reads, an unused opcode
      send_word(fpms_pkg::FN_POP, '0, '0, '0, '0, '0, '0);
      send_word(fpms_pkg::FN_READ, '0, '0, '0, '0, '0, 4'd0);
      send_word(fpms_pkg::FN_PUSHID, '0, '0, '0, '0, '0, '0);
      send_word(fpms_pkg::FN_ROTX, 16'd0, 16'd16384, '0, '0, '0, '0);
      send_word(fpms_pkg::FN_ROTX, 16'd16384, 16'd0, '0, '0, '0, '0);
      send_word(fpms_pkg::FN_ROTY, -16'sd16384, 16'd0, '0, '0, '0, '0);
      send_word(fpms_pkg::FN_ROTZ, 16'd11585, -16'sd11585, '0, '0, '0, '0);
      send_word(fpms_pkg::FN_TSET, '0, '0, 32'h7fff_ffff, 32'h8000_0000,
                32'hffff_ffff, '0);
      send_word(fpms_pkg::FN_TREL, '0, '0, 32'h8000_0000, 32'h7fff_ffff, 32'd3, '0);
      send_word(fpms_pkg::FN_TABS, '0, '0, 32'd1, 32'hffff_ffff, 32'd5, '0);
      for (int i = 0; i < 16; i += 3)
         send_word(fpms_pkg::FN_READ, '0, '0, '0, '0, '0, 4'(i));
      send_word(4'd15, 16'hffff, 16'hffff, '1, '1, '1, 4'hf);
      send_word(fpms_pkg::FN_READ, '0, '0, '0, '0, '0, fpms_pkg::IDX_RESET);
      send_word(fpms_pkg::FN_POP, '0, '0, '0, '0, '0, '0);
      drain();

      // fill to the top, refused pushes, reset to level 0
      for (int i = 0; i < STACK_DEPTH + 1; i++)
         send_word((i % 2) ? fpms_pkg::FN_PUSH : fpms_pkg::FN_PUSHID,
                   '0, '0, '0, '0, '0, '0);
      send_word(fpms_pkg::FN_READ, '0, '0, '0, '0, '0, 4'd11);
      send_word(fpms_pkg::FN_READ, '0, '0, '0, '0, '0, fpms_pkg::IDX_RESET);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_origin(fpms_pkg::CSR_OX, phase == 3 ? 32'h8000_0000 : $urandom);
         write_origin(fpms_pkg::CSR_OY, phase == 3 ? 32'h7fff_ffff : $urandom);
         write_origin(fpms_pkg::CSR_OZ, phase == 0 ? 32'd0 : $urandom);
         csr_we <= 0;
         calm = (phase == 3);
         for (int k = 0; k < 100; k++) begin
            if (phase == 1 && k == 20) hold_start = 1;
            if (phase == 2 && k == 50) begin
               req_tvalid <= 0;
               @(posedge clock);
               spin = 0;
               while (pending_count != 0 && spin < 20000) begin
                  @(posedge clock);
                  spin++;
               end
            end
            send_random();
         end
         drain();
      end

      $display("Sent %0d words (%0d rotations, %0d translations, %0d stack/read/other),",
               sent, rot_count, trans_count, stack_count);
      $display("checked %0d results across 5 origin settings.", result_count);
      if (fail_count == 0 && pending_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // long receiver hold-off once requested
   always @(posedge clock) begin
      int held;
      if (reset) held = 0;
      else if (hold_start && held < 600) held++;
      hold_rsp <= hold_start && held < 600;
   end
endmodule
